// File: rtl/lrgm_pkg.sv
// Package for the lattice rod grand canonical move block.
// Holds widths, codes, item and control structs and the cell stepping function.
// No dependencies.
package lrgm_pkg;

	localparam int MAX_DIM  = 64;
	localparam int DIM_W    = 6;
	localparam int DIMV_W   = 7;
	localparam int CELL_W   = 12;
	localparam int MAX_RODS = 4096;
	localparam int CNT_W    = 13;
	localparam int LEN_W    = 5;
	localparam int Z_W      = 24;
	localparam int D_W      = 16;
	localparam int PICK_W   = 31;
	localparam int MA_W     = 54;
	localparam int MB_W     = 50;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_DELETED  = 3'd1,
		ST_REJECTED = 3'd2,
		ST_BLOCKED  = 3'd3,
		ST_NO_RODS  = 3'd4,
		ST_BAD_POS  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_ACTIVITY = 2'd0,
		REG_LENGTH   = 2'd1,
		REG_ROWS     = 2'd2,
		REG_COLS     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		K_ADD     = 2'd0,
		K_ADD_BAD = 2'd1,
		K_DEL     = 2'd2
	} kind_t;

	// effective configuration, already saturated
	typedef struct packed {
		logic [Z_W-1:0]    z;
		logic [LEN_W-1:0]  l;
		logic [DIMV_W-1:0] r;
		logic [DIMV_W-1:0] c;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic               vert;
		logic [DIM_W-1:0]   x;
		logic [DIM_W-1:0]   y;
		logic [D_W-1:0]     d;
		logic [PICK_W-1:0]  pick;
	} item_t;

	// queue head toward the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// back end control toward the front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} bctl_t;

	// next cell along the rod, wrapping at the lattice size in use
	function automatic logic [CELL_W-1:0] cell_step(input logic vert,
			input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y,
			input logic [DIMV_W-1:0] r, input logic [DIMV_W-1:0] c);
		logic [DIMV_W-1:0] nx;
		logic [DIMV_W-1:0] ny;
		nx = {1'b0, x} + DIMV_W'(1);
		ny = {1'b0, y} + DIMV_W'(1);
		if (vert) begin
			if (ny == r) ny = '0;
			return {ny[DIM_W-1:0], x};
		end else begin
			if (nx == c) nx = '0;
			return {y, nx[DIM_W-1:0]};
		end
	endfunction

endpackage

// File: rtl/lattice_rod_gcmc_move.sv
// Top level of the lattice rod grand canonical move block: configuration
// registers, front end queue and back end sequencer. Depends on lrgm_pkg, lrgm_front, lrgm_back.
//
// channel | dir | handshake           | payload
// s       | in  | s_tvalid/s_tready   | s_tdata, s_tuser
// m       | out | m_tvalid/m_tready   | m_tdata, m_tuser
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After reset the occupancy memory is cleared, with s_tready low.
// Addition: the origin and then each further cell is read, then every cell is written.
// Deletion: acceptance products, the 31-step remainder unit, reduction of a stored
// origin that lies outside a reduced lattice (one subtract per cycle), clearing of
// the cells and the list compaction through the read and write ports of the list RAM.
// A two-item queue lets s accept up to two items while the back end works or m stalls.
module lattice_rod_gcmc_move (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pos_x, pos_y, accept_draw, pick_draw, zero pad
	input  logic [1:0]  s_tuser,   // func, orient
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // vertical_count, horizontal_count, zero pad
	output logic [2:0]  m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import lrgm_pkg::*;

	logic [Z_W-1:0]    act_q;
	logic [LEN_W-1:0]  len_q;
	logic [DIMV_W-1:0] rows_q, cols_q;
	cfg_t              cfg;
	head_t             head;
	bctl_t             bctl;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= Z_W'(65536);
			len_q  <= LEN_W'(1);
			rows_q <= DIMV_W'(MAX_DIM);
			cols_q <= DIMV_W'(MAX_DIM);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACTIVITY: act_q  <= cfg_data;
				REG_LENGTH:   len_q  <= cfg_data[LEN_W-1:0];
				REG_ROWS:     rows_q <= cfg_data[DIMV_W-1:0];
				REG_COLS:     cols_q <= cfg_data[DIMV_W-1:0];
				default:      act_q  <= act_q;
			endcase
		end
	end

	// saturate to the usable range
	always_comb begin
		cfg.z = act_q;
		cfg.l = (len_q == '0) ? LEN_W'(1) : len_q;
		cfg.r = (rows_q == '0) ? DIMV_W'(1) :
			(rows_q > DIMV_W'(MAX_DIM)) ? DIMV_W'(MAX_DIM) : rows_q;
		cfg.c = (cols_q == '0) ? DIMV_W'(1) :
			(cols_q > DIMV_W'(MAX_DIM)) ? DIMV_W'(MAX_DIM) : cols_q;
	end

	lrgm_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.bctl(bctl), .head(head)
	);

	lrgm_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .head(head), .bctl(bctl),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);
endmodule

// File: rtl/lrgm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lrgm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem_q[rd_addr];
	end
endmodule

// File: rtl/lrgm_front.sv
// Front end: accepts input items, classifies them and queues them (two entries).
// Depends on lrgm_pkg.
module lrgm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lrgm_pkg::cfg_t                    cfg,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [63:0]                       s_tdata,
	input  logic [1:0]                        s_tuser,
	input  lrgm_pkg::bctl_t                   bctl,
	output lrgm_pkg::head_t                   head
);
	import lrgm_pkg::*;

	item_t      fifo_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       push, pop;

	// classify: decode kind and check the origin against the lattice in use
	always_comb begin
		in_item.vert = ~s_tuser[1];
		in_item.x    = s_tdata[5:0];
		in_item.y    = s_tdata[11:6];
		in_item.d    = s_tdata[27:12];
		in_item.pick = s_tdata[58:28];
		if (s_tuser[0])
			in_item.kind = K_DEL;
		else if (({1'b0, s_tdata[5:0]} >= cfg.c) || ({1'b0, s_tdata[11:6]} >= cfg.r))
			in_item.kind = K_ADD_BAD;
		else
			in_item.kind = K_ADD;
	end

	assign s_tready   = ~bctl.clearing && (cnt_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign pop        = bctl.pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = fifo_q[rptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= in_item;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: rtl/lrgm_back.sv
// Back end: sequencer that carries out one move at a time on the occupancy
// and rod list memories, and holds the result register. Depends on lrgm_pkg, lrgm_ram.
module lrgm_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lrgm_pkg::cfg_t         cfg,
	input  lrgm_pkg::head_t        head,
	output lrgm_pkg::bctl_t        bctl,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,
	output logic [2:0]             m_tuser
);
	import lrgm_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_A_RD0, S_A_MUL1, S_A_MUL2, S_A_CMP, S_A_WRD, S_A_WCHK, S_A_FULL,
		S_A_SET, S_A_LIST,
		S_D_MUL1, S_D_MUL2, S_D_MUL3, S_D_CMP, S_D_DIV, S_D_LRD, S_D_LDAT,
		S_D_MOD, S_D_CLR, S_D_SCHK, S_D_SWR, S_D_DONE,
		S_FIN
	} state_t;

	state_t             state_q;
	item_t              it_q;
	logic [CELL_W-1:0]  clr_q;
	logic [CNT_W-1:0]   vcnt_q, hcnt_q;
	logic [DIM_W-1:0]   cx_q, cy_q;
	logic [LEN_W-1:0]   i_q;
	logic [MA_W-1:0]    ma_q;
	logic [MB_W-1:0]    mb_q;
	logic [CNT_W-1:0]   rem_q;
	logic [PICK_W-1:0]  pick_q;
	logic [4:0]         bit_q;
	logic [CELL_W-1:0]  j_q;
	status_t            res_q;
	logic               m_valid_q;
	status_t            m_status_q;
	logic [CNT_W-1:0]   m_vcnt_q, m_hcnt_q;

	logic [CNT_W-1:0]   n;
	logic [CNT_W:0]     div_try;
	logic               more;
	logic               res_load;
	logic [CELL_W-1:0]  nxt_cell;
	logic               occ_wr_en, occ_wr_data, occ_rd_en, occ_rd_data;
	logic [CELL_W-1:0]  occ_wr_addr, occ_rd_addr;
	logic               l_wr, l_rd_en;
	logic [CELL_W-1:0]  l_wr_addr, l_rd_addr, l_wr_data, vl_rd_data, hl_rd_data, l_rd_data;

	assign n        = it_q.vert ? vcnt_q : hcnt_q;
	assign div_try  = {rem_q, pick_q[PICK_W-1]};
	assign more     = ({1'b0, j_q} + CNT_W'(1)) < n;
	assign nxt_cell = cell_step(it_q.vert, cx_q, cy_q, cfg.r, cfg.c);
	assign l_rd_data = it_q.vert ? vl_rd_data : hl_rd_data;
	assign res_load = (state_q == S_FIN) && (!m_valid_q || m_tready);

	// memory control from state
	always_comb begin
		occ_wr_en   = (state_q == S_CLR) || (state_q == S_A_SET) || (state_q == S_D_CLR);
		occ_wr_addr = (state_q == S_CLR) ? clr_q : {cy_q, cx_q};
		occ_wr_data = (state_q == S_A_SET);
		occ_rd_en   = (state_q == S_A_RD0) || (state_q == S_A_WRD);
		occ_rd_addr = (state_q == S_A_RD0) ? {it_q.y, it_q.x} : {cy_q, cx_q};
		l_wr        = (state_q == S_A_LIST) || (state_q == S_D_SWR);
		l_wr_addr   = (state_q == S_A_LIST) ? n[CELL_W-1:0] : j_q;
		l_wr_data   = (state_q == S_A_LIST) ? {it_q.y, it_q.x} : l_rd_data;
		l_rd_en     = (state_q == S_D_LRD) || ((state_q == S_D_SCHK) && more);
		l_rd_addr   = (state_q == S_D_LRD) ? rem_q[CELL_W-1:0] : (j_q + CELL_W'(1));
	end

	assign bctl.pop      = (state_q == S_IDLE) && head.valid;
	assign bctl.clearing = (state_q == S_CLR);

	lrgm_ram #(.WIDTH(1), .DEPTH(MAX_DIM * MAX_DIM)) u_occ (
		.clk(clk), .wr_en(occ_wr_en), .wr_addr(occ_wr_addr), .wr_data(occ_wr_data),
		.rd_en(occ_rd_en), .rd_addr(occ_rd_addr), .rd_data(occ_rd_data)
	);
	lrgm_ram #(.WIDTH(CELL_W), .DEPTH(MAX_RODS)) u_vlist (
		.clk(clk), .wr_en(l_wr && it_q.vert), .wr_addr(l_wr_addr), .wr_data(l_wr_data),
		.rd_en(l_rd_en && it_q.vert), .rd_addr(l_rd_addr), .rd_data(vl_rd_data)
	);
	lrgm_ram #(.WIDTH(CELL_W), .DEPTH(MAX_RODS)) u_hlist (
		.clk(clk), .wr_en(l_wr && !it_q.vert), .wr_addr(l_wr_addr), .wr_data(l_wr_data),
		.rd_en(l_rd_en && !it_q.vert), .rd_addr(l_rd_addr), .rd_data(hl_rd_data)
	);

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {6'b0, m_hcnt_q, m_vcnt_q};

	// move sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			vcnt_q    <= '0;
			hcnt_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (res_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (head.valid) begin
						it_q <= head.item;
						unique case (head.item.kind)
							K_ADD: state_q <= S_A_RD0;
							K_ADD_BAD: begin
								res_q   <= ST_BAD_POS;
								state_q <= S_FIN;
							end
							K_DEL: begin
								if ((head.item.vert ? vcnt_q : hcnt_q) == '0) begin
									res_q   <= ST_NO_RODS;
									state_q <= S_FIN;
								end else state_q <= S_D_MUL1;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// addition
				S_A_RD0: state_q <= S_A_MUL1;
				S_A_MUL1: begin
					if (occ_rd_data) begin
						res_q   <= ST_BLOCKED;
						state_q <= S_FIN;
					end else begin
						ma_q    <= MA_W'(it_q.d) * MA_W'(n + CNT_W'(1));
						mb_q    <= MB_W'(cfg.z) * MB_W'(cfg.r);
						state_q <= S_A_MUL2;
					end
				end
				S_A_MUL2: begin
					ma_q    <= (MA_W'(ma_q[28:0]) * MA_W'(cfg.l)) << 1;
					mb_q    <= MB_W'(mb_q[30:0]) * MB_W'(cfg.c);
					state_q <= S_A_CMP;
				end
				S_A_CMP: begin
					{cy_q, cx_q} <= cell_step(it_q.vert, it_q.x, it_q.y, cfg.r, cfg.c);
					i_q <= LEN_W'(1);
					if (ma_q > MA_W'(mb_q)) begin
						res_q   <= ST_REJECTED;
						state_q <= S_FIN;
					end else if (cfg.l == LEN_W'(1)) state_q <= S_A_FULL;
					else state_q <= S_A_WRD;
				end
				S_A_WRD: state_q <= S_A_WCHK;
				S_A_WCHK: begin
					if (occ_rd_data) begin
						res_q   <= ST_BLOCKED;
						state_q <= S_FIN;
					end else if (i_q + LEN_W'(1) < cfg.l) begin
						{cy_q, cx_q} <= nxt_cell;
						i_q          <= i_q + LEN_W'(1);
						state_q      <= S_A_WRD;
					end else state_q <= S_A_FULL;
				end
				S_A_FULL: begin
					cx_q <= it_q.x;
					cy_q <= it_q.y;
					i_q  <= '0;
					if (n >= CNT_W'(MAX_RODS)) begin
						res_q   <= ST_BLOCKED;
						state_q <= S_FIN;
					end else state_q <= S_A_SET;
				end
				S_A_SET: begin
					{cy_q, cx_q} <= nxt_cell;
					i_q          <= i_q + LEN_W'(1);
					if (i_q + LEN_W'(1) == cfg.l) state_q <= S_A_LIST;
				end
				S_A_LIST: begin
					if (it_q.vert) vcnt_q <= vcnt_q + CNT_W'(1);
					else hcnt_q <= hcnt_q + CNT_W'(1);
					res_q   <= ST_ADDED;
					state_q <= S_FIN;
				end
				// deletion: acceptance products first
				S_D_MUL1: begin
					ma_q    <= MA_W'(it_q.d) * MA_W'(cfg.z);
					mb_q    <= (MB_W'(n) * MB_W'(cfg.l)) << 33;
					state_q <= S_D_MUL2;
				end
				S_D_MUL2: begin
					ma_q    <= MA_W'(ma_q[39:0]) * MA_W'(cfg.r);
					state_q <= S_D_MUL3;
				end
				S_D_MUL3: begin
					ma_q    <= MA_W'(ma_q[46:0]) * MA_W'(cfg.c);
					state_q <= S_D_CMP;
				end
				S_D_CMP: begin
					rem_q  <= '0;
					pick_q <= it_q.pick;
					bit_q  <= '0;
					if (MA_W'(mb_q) < ma_q) begin
						res_q   <= ST_REJECTED;
						state_q <= S_FIN;
					end else state_q <= S_D_DIV;
				end
				// victim index: restoring remainder, one bit per cycle
				S_D_DIV: begin
					if (div_try >= {1'b0, n}) rem_q <= CNT_W'(div_try - {1'b0, n});
					else rem_q <= div_try[CNT_W-1:0];
					pick_q <= pick_q << 1;
					bit_q  <= bit_q + 5'd1;
					if (bit_q == 5'(PICK_W - 1)) state_q <= S_D_LRD;
				end
				S_D_LRD: state_q <= S_D_LDAT;
				S_D_LDAT: begin
					cx_q    <= l_rd_data[DIM_W-1:0];
					cy_q    <= l_rd_data[CELL_W-1:DIM_W];
					i_q     <= '0;
					state_q <= S_D_MOD;
				end
				// reduce the stored origin to the lattice in use
				S_D_MOD: begin
					if ({1'b0, cx_q} >= cfg.c) cx_q <= DIM_W'({1'b0, cx_q} - cfg.c);
					else if ({1'b0, cy_q} >= cfg.r) cy_q <= DIM_W'({1'b0, cy_q} - cfg.r);
					else state_q <= S_D_CLR;
				end
				S_D_CLR: begin
					{cy_q, cx_q} <= nxt_cell;
					i_q          <= i_q + LEN_W'(1);
					j_q          <= rem_q[CELL_W-1:0];
					if (i_q + LEN_W'(1) == cfg.l) state_q <= S_D_SCHK;
				end
				// close the gap in the list: each later entry moves down by one
				S_D_SCHK: state_q <= more ? S_D_SWR : S_D_DONE;
				S_D_SWR: begin
					j_q     <= j_q + CELL_W'(1);
					state_q <= S_D_SCHK;
				end
				S_D_DONE: begin
					if (it_q.vert) vcnt_q <= vcnt_q - CNT_W'(1);
					else hcnt_q <= hcnt_q - CNT_W'(1);
					res_q   <= ST_DELETED;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_load) begin
						m_status_q <= res_q;
						m_vcnt_q   <= vcnt_q;
						m_hcnt_q   <= hcnt_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_vcnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CNT_W'(MAX_RODS)) else $error("vertical count overflow");
	a_hcnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= CNT_W'(MAX_RODS)) else $error("horizontal count overflow");
	a_no_pop_clr: assert property (@(posedge clk) disable iff (!arst_n)
		bctl.clearing |-> !bctl.pop) else $error("item taken during clearing pass");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_status_q <= ST_BAD_POS))
		else $error("bad status code");
	a_one_change: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == S_FIN |-> $stable(vcnt_q) && $stable(hcnt_q))
		else $error("count changed while delivering result");
endmodule
